/* rtl/assert_macros.svh */
// Assertion macros for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* rtl/ewrg_pkg.sv */
// Package with the codes, widths and constants of the event wake rate gate.
package ewrg_pkg;

  // Default number of event types held in the fire-time memory.
  localparam int NUM_TYPES_DEF = 16;

  // Field widths.
  localparam int FUNC_W     = 2;
  localparam int TYPE_W     = 4;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 32;
  localparam int MASK_W     = 16;
  localparam int BUDGET_W   = 16;
  localparam int BUCKET_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths, rounded up to whole bytes.
  localparam int S_FIELDS_W = FUNC_W + TYPE_W + TIME_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = STATUS_W + TYPE_W + 2 * COUNT_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_STAGE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAKE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TRY   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_LATCHED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ALLOW    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_COOLDOWN = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_BUDGET   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_TAKEN    = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_HOUR  = 2'd2;

  // Configuration reset values.
  localparam logic [MASK_W-1:0]   RST_ENABLED_MASK = 16'd6;
  localparam logic [TIME_W-1:0]   RST_COOLDOWN_MS  = 32'd60000;
  localparam logic [BUDGET_W-1:0] RST_BUDGET_HOUR  = 16'd4;

  // Hour bucket division: 3600000 = 2^7 * 28125. The dividend is shifted
  // by seven, then multiplied by a rounded-up reciprocal of the odd part.
  localparam longint unsigned HOUR_MS     = 64'd3600000;
  localparam int              HOUR_SHIFT  = 7;
  localparam longint unsigned HOUR_ODD    = HOUR_MS >> HOUR_SHIFT;
  localparam int              DVD_W       = TIME_W - HOUR_SHIFT;
  localparam int              ODD_W       = $clog2(HOUR_ODD);
  localparam int              RECIP_SHIFT = DVD_W + ODD_W;
  localparam int              RECIP_W     = RECIP_SHIFT - ODD_W + 1;
  localparam int              PROD_W      = DVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] HOUR_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + HOUR_ODD - 64'd1) / HOUR_ODD);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CALC   = 3'b010,
    S_DECIDE = 3'b100
  } seq_state_t;

endpackage

/* rtl/event_wake_rate_gate_unit.sv */
// Event wake rate gate: stage/take latch, per-type cooldown and hourly budget.
//
// Items enter on the s_ channel (func, event_type, now_ms) and each gives
// exactly one result on the m_ channel (status, taken_type and both running
// counters). Configuration registers are written through cfg_we, cfg_index
// and cfg_wdata, by the user only while the gate is idle (not enforced).
//
// One item is in work at a time. An accepted item reads its fire-time memory
// entry at acceptance, then passes the hour bucket multiplier and the
// cooldown compare, then is decided and written back; the result becomes
// valid at the same edge at which s_tready returns, once the output register
// is free.
//
// The result sits in an output register: a new item is taken while it waits,
// and the decision of that item waits until the register has drained. A
// stalled receiver thus holds the gate after at most one more item.
// Synchronous reset empties the latch, clears all fired flags, the hour
// bucket, the wake count and both counters, and restores the configuration.
module event_wake_rate_gate_unit #(
  parameter int NUM_TYPES = ewrg_pkg::NUM_TYPES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // func [1:0], event_type [5:2], now_ms [37:6], zero fill
  input  logic [ewrg_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [2:0], taken_type [6:3], drop_count [38:7],
  // suppress_count [70:39], zero fill
  output logic [ewrg_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [ewrg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ewrg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ewrg_pkg::*;

  localparam int AW = $clog2(NUM_TYPES);

  // Configuration registers.
  logic [MASK_W-1:0]   enabled_type_mask;
  logic [TIME_W-1:0]   cooldown_ms;
  logic [BUDGET_W-1:0] budget_per_hour;

  // Sequencer and item registers.
  seq_state_t        state, state_next;
  logic [FUNC_W-1:0] func_r;
  logic [TYPE_W-1:0] type_r;
  logic [TIME_W-1:0] now_r;
  logic [AW-1:0]     addr_r;
  logic              type_ok_r;
  logic              cool_hit;

  // Gate state.
  logic [TYPE_W-1:0]   latched_type, latched_type_next;
  logic [BUCKET_W-1:0] hour_bucket, hour_bucket_next;
  logic [BUDGET_W-1:0] bucket_wakes, bucket_wakes_next;
  logic [COUNT_W-1:0]  drops, drops_next;
  logic [COUNT_W-1:0]  suppressions, suppressions_next;

  // Input unpacking and handshake.
  logic [FUNC_W-1:0]   s_func;
  logic [TYPE_W-1:0]   s_type;
  logic [TIME_W-1:0]   s_now;
  logic                s_accept;
  logic                s_type_ok;
  logic [AW-1:0]       s_addr;
  logic                out_free;
  logic                commit;

  // Memory, divider and decision signals.
  logic [TIME_W-1:0]   mem_rdata;
  logic                mem_fired;
  logic [BUCKET_W-1:0] bucket;
  logic [TIME_W-1:0]   elapsed;
  logic [BUDGET_W-1:0] wakes_eff;
  logic [STATUS_W-1:0] status_n;
  logic [TYPE_W-1:0]   taken_n;
  logic                fire;

  assign s_func   = s_tdata[FUNC_W-1:0];
  assign s_type   = s_tdata[FUNC_W +: TYPE_W];
  assign s_now    = s_tdata[FUNC_W + TYPE_W +: TIME_W];
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_DECIDE) && out_free;

  // A type is usable when it is not none and lies below the type count.
  assign s_type_ok = (s_type != '0) && ({26'd0, s_type} < 30'(NUM_TYPES));
  assign s_addr    = AW'(s_type);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_type_mask <= RST_ENABLED_MASK;
      cooldown_ms       <= RST_COOLDOWN_MS;
      budget_per_hour   <= RST_BUDGET_HOUR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED_MASK: enabled_type_mask <= cfg_wdata[MASK_W-1:0];
        REG_COOLDOWN_MS:  cooldown_ms       <= cfg_wdata[TIME_W-1:0];
        REG_BUDGET_HOUR:  budget_per_hour   <= cfg_wdata[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accept, compute, decide.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_accept) state_next = S_CALC;
      S_CALC:   state_next = S_DECIDE;
      S_DECIDE: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers, loaded at acceptance.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      func_r    <= s_func;
      type_r    <= s_type;
      now_r     <= s_now;
      addr_r    <= s_addr;
      type_ok_r <= s_type_ok;
    end
  end

  ewrg_fire_mem #(
    .NUM_TYPES (NUM_TYPES),
    .AW        (AW)
  ) u_fire_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s_accept && s_type_ok),
    .rd_addr  (s_addr),
    .wr_en    (commit && fire),
    .wr_addr  (addr_r),
    .wr_data  (now_r),
    .rd_data  (mem_rdata),
    .rd_fired (mem_fired)
  );

  ewrg_hour_div u_hour_div (
    .clk    (clk),
    .en     (state == S_CALC),
    .now    (now_r),
    .bucket (bucket)
  );

  // Wrap-safe cooldown check against the stored fire time.
  assign elapsed = now_r - mem_rdata;

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      cool_hit <= mem_fired && (elapsed < cooldown_ms);
    end
  end

  // Decision for the item in work.
  assign wakes_eff = (bucket != hour_bucket) ? '0 : bucket_wakes;

  always_comb begin
    status_n          = STAT_IGNORED;
    taken_n           = '0;
    fire              = 1'b0;
    latched_type_next = latched_type;
    hour_bucket_next  = hour_bucket;
    bucket_wakes_next = bucket_wakes;
    drops_next        = drops;
    suppressions_next = suppressions;
    case (func_r)
      FUNC_STAGE: begin
        if (type_ok_r && enabled_type_mask[type_r]) begin
          if (latched_type != '0) begin
            drops_next = drops + 1'b1;
            status_n   = STAT_DROPPED;
          end else begin
            latched_type_next = type_r;
            status_n          = STAT_LATCHED;
          end
        end
      end
      FUNC_TAKE: begin
        if (latched_type != '0) begin
          taken_n           = latched_type;
          latched_type_next = '0;
          status_n          = STAT_TAKEN;
        end
      end
      FUNC_TRY: begin
        if (!type_ok_r) begin
          status_n = STAT_COOLDOWN;
        end else if (cool_hit) begin
          suppressions_next = suppressions + 1'b1;
          status_n          = STAT_COOLDOWN;
        end else begin
          // The bucket change is kept even when the budget suppresses.
          hour_bucket_next = bucket;
          if (wakes_eff >= budget_per_hour) begin
            bucket_wakes_next = wakes_eff;
            suppressions_next = suppressions + 1'b1;
            status_n          = STAT_BUDGET;
          end else begin
            bucket_wakes_next = wakes_eff + 1'b1;
            fire              = 1'b1;
            status_n          = STAT_ALLOW;
          end
        end
      end
      default: ;
    endcase
  end

  // Gate state commits together with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_type <= '0;
      hour_bucket  <= '0;
      bucket_wakes <= '0;
      drops        <= '0;
      suppressions <= '0;
    end else if (commit) begin
      latched_type <= latched_type_next;
      hour_bucket  <= hour_bucket_next;
      bucket_wakes <= bucket_wakes_next;
      drops        <= drops_next;
      suppressions <= suppressions_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= M_TDATA_W'({suppressions_next, drops_next, taken_n, status_n});
    end
  end

endmodule

/* rtl/ewrg_fire_mem.sv */
// Per-type memory of last allowed fire times with registered read.
module ewrg_fire_mem #(
  parameter int NUM_TYPES = ewrg_pkg::NUM_TYPES_DEF,
  parameter int AW        = $clog2(NUM_TYPES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ewrg_pkg::TIME_W-1:0] wr_data,
  output logic [ewrg_pkg::TIME_W-1:0] rd_data,
  output logic                        rd_fired
);
  import ewrg_pkg::*;

  logic [TIME_W-1:0]    mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] fired;

  // Fire time storage, one write and one read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_fired <= fired[rd_addr];
    end
  end

  // A type counts as fired once it has been written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      fired <= '0;
    end else if (wr_en) begin
      fired[wr_addr] <= 1'b1;
    end
  end

endmodule

/* rtl/ewrg_hour_div.sv */
// Hour bucket of a millisecond time, by multiplication with a reciprocal.
module ewrg_hour_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ewrg_pkg::TIME_W-1:0]   now,
  output logic [ewrg_pkg::BUCKET_W-1:0] bucket
);
  import ewrg_pkg::*;

  logic [DVD_W-1:0]  dvd;
  logic [PROD_W-1:0] prod;

  // Strip the power of two out of the hour length first.
  assign dvd = now[TIME_W-1:HOUR_SHIFT];

  // The rounded-up reciprocal gives the exact quotient for every dividend.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(dvd) * PROD_W'(HOUR_RECIP);
    end
  end

  assign bucket = prod[RECIP_SHIFT +: BUCKET_W];

endmodule

/* rtl/ewrg_checker.sv */
// Port-level checker for the event wake rate gate and its bind statement.
`include "assert_macros.svh"

module ewrg_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ewrg_pkg::M_TDATA_W-1:0] m_tdata
);
  import ewrg_pkg::*;

  // Reset leaves no result pending.
  `ASSERT_CLK(a_reset_clears_out, clk, rst |=> !m_tvalid)

  // A taken type appears only with the taken status, and never as none.
  `ASSERT_CLK_RST(a_taken_consistent, clk, rst,
    m_tvalid |-> ((m_tdata[6:3] != '0) == (m_tdata[2:0] == STAT_TAKEN)))

  // The gate works on one item at a time: it is busy right after acceptance.
  `ASSERT_CLK_RST(a_busy_after_accept, clk, rst, (s_tvalid && s_tready) |=> !s_tready)

  // A stalled result stays valid and unchanged.
  `ASSERT_CLK_RST(a_out_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind event_wake_rate_gate_unit ewrg_port_checker u_ewrg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
